// ===== src/scar_pkg.sv =====
// ----------------------------------------------------------------------------
// scar_pkg
// Shared types, constants and line tables for the stereo comb/allpass reverb.
// ----------------------------------------------------------------------------
package scar_pkg;

    localparam int LINE_RATE_HZ   = 44100;
    localparam int STEREO_SPREAD  = 23;
    localparam int COMB_N         = 8;
    localparam int AP_N           = 4;
    localparam int SAMPLE_BITS    = 24;
    localparam int COEF_FRAC_BITS = 16;

    localparam int ONE       = 1 << COEF_FRAC_BITS;
    localparam int GAIN      = (15 * ONE + 500) / 1000;
    localparam int DAMP_MAX  = (4 * ONE + 5) / 10;
    localparam int WET_MAX   = 3 * ONE;
    localparam int DRY_MAX   = 2 * ONE;

    localparam int ACC_W  = 56;
    localparam int SUM_W  = 32 + $clog2(COMB_N) + 1;
    localparam int CFG_W  = 18;

    localparam logic [2:0] CFG_ROOM  = 3'd0;
    localparam logic [2:0] CFG_DAMP  = 3'd1;
    localparam logic [2:0] CFG_WET   = 3'd2;
    localparam logic [2:0] CFG_DRY   = 3'd3;
    localparam logic [2:0] CFG_WIDTH = 3'd4;
    localparam logic [2:0] CFG_HOLD  = 3'd5;

    localparam int COMB_BASE [COMB_N] = '{1116, 1188, 1277, 1356, 1422, 1491, 1557, 1617};
    localparam int AP_BASE   [AP_N]   = '{556, 441, 341, 225};

    function automatic int f_line_len(input int n);
        int l;
        l = (n * LINE_RATE_HZ + 22050) / 44100;
        return (l == 0) ? 1 : l;
    endfunction

    function automatic int f_comb_depth();
        int s;
        s = 0;
        for (int ch = 0; ch < 2; ch++)
            for (int i = 0; i < COMB_N; i++)
                s += f_line_len(COMB_BASE[i] + ch * STEREO_SPREAD);
        return s;
    endfunction

    function automatic int f_ap_depth();
        int s;
        s = 0;
        for (int ch = 0; ch < 2; ch++)
            for (int i = 0; i < AP_N; i++)
                s += f_line_len(AP_BASE[i] + ch * STEREO_SPREAD);
        return s;
    endfunction

    localparam int COMB_DEPTH = f_comb_depth();
    localparam int AP_DEPTH   = f_ap_depth();
    localparam int CA_W = $clog2(COMB_DEPTH);
    localparam int AA_W = $clog2(AP_DEPTH);
    localparam int CP_W = $clog2(f_line_len(COMB_BASE[COMB_N-1] + STEREO_SPREAD));
    localparam int AP_W = $clog2(f_line_len(AP_BASE[0] + STEREO_SPREAD));
    localparam int CK_W = $clog2(2 * COMB_N);
    localparam int AK_W = $clog2(2 * AP_N);

    typedef logic [CA_W-1:0] t_caddr;
    typedef logic [AA_W-1:0] t_aaddr;
    typedef t_caddr [2*COMB_N-1:0] t_caddr_tab;
    typedef t_aaddr [2*AP_N-1:0] t_aaddr_tab;
    typedef logic [CP_W-1:0] t_cpos;
    typedef logic [AP_W-1:0] t_apos;
    typedef t_cpos [2*COMB_N-1:0] t_cpos_tab;
    typedef t_apos [2*AP_N-1:0] t_apos_tab;

    function automatic t_caddr_tab f_comb_off();
        t_caddr_tab t;
        int off;
        off = 0;
        for (int ch = 0; ch < 2; ch++)
            for (int i = 0; i < COMB_N; i++) begin
                t[ch*COMB_N+i] = CA_W'(off);
                off += f_line_len(COMB_BASE[i] + ch * STEREO_SPREAD);
            end
        return t;
    endfunction

    function automatic t_cpos_tab f_comb_last();
        t_cpos_tab t;
        for (int ch = 0; ch < 2; ch++)
            for (int i = 0; i < COMB_N; i++)
                t[ch*COMB_N+i] = CP_W'(f_line_len(COMB_BASE[i] + ch * STEREO_SPREAD) - 1);
        return t;
    endfunction

    function automatic t_aaddr_tab f_ap_off();
        t_aaddr_tab t;
        int off;
        off = 0;
        for (int ch = 0; ch < 2; ch++)
            for (int i = 0; i < AP_N; i++) begin
                t[ch*AP_N+i] = AA_W'(off);
                off += f_line_len(AP_BASE[i] + ch * STEREO_SPREAD);
            end
        return t;
    endfunction

    function automatic t_apos_tab f_ap_last();
        t_apos_tab t;
        for (int ch = 0; ch < 2; ch++)
            for (int i = 0; i < AP_N; i++)
                t[ch*AP_N+i] = AP_W'(f_line_len(AP_BASE[i] + ch * STEREO_SPREAD) - 1);
        return t;
    endfunction

    localparam t_caddr_tab COMB_OFF  = f_comb_off();
    localparam t_cpos_tab  COMB_LAST = f_comb_last();
    localparam t_aaddr_tab AP_OFF    = f_ap_off();
    localparam t_apos_tab  AP_LAST   = f_ap_last();

    typedef struct packed {
        logic                          action;
        logic signed [SAMPLE_BITS-1:0] in_left;
        logic signed [SAMPLE_BITS-1:0] in_right;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] out_left;
        logic signed [SAMPLE_BITS-1:0] out_right;
    } t_out_item;

    typedef enum logic [4:0] {
        ST_IDLE, ST_CLEAR, ST_GAIN, ST_XSAT, ST_WL, ST_WLS, ST_WR, ST_WRS,
        ST_C_RD, ST_C_M1, ST_C_M2, ST_C_LP, ST_C_FB, ST_C_WR,
        ST_A_RD, ST_A_WR, ST_MIX1, ST_MIX2, ST_MIX3, ST_MIXS
    } t_state;

    function automatic logic signed [63:0] f_rnd(input logic signed [ACC_W-1:0] v,
                                                 input int s);
        logic signed [63:0] w;
        w = 64'(v) + (64'sd1 <<< (s - 1));
        return w >>> s;
    endfunction

    function automatic logic signed [31:0] f_sat32(input logic signed [63:0] v);
        if (v > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
        if (v < -64'sh8000_0000) return -32'sh8000_0000;
        return 32'(v);
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] f_sat_smp(input logic signed [63:0] v);
        logic signed [63:0] hi;
        hi = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
        if (v > hi) return SAMPLE_BITS'(hi);
        if (v < -hi - 64'sd1) return SAMPLE_BITS'(-hi - 64'sd1);
        return SAMPLE_BITS'(v);
    endfunction

endpackage

// ===== src/scar_ram.sv =====
// ----------------------------------------------------------------------------
// scar_ram
// Single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module scar_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== src/stereo_comb_allpass_reverb_core.sv =====
// ----------------------------------------------------------------------------
// stereo_comb_allpass_reverb_core
// Stereo reverb: damped feedback combs, allpass chain, width/wet/dry mix.
// ----------------------------------------------------------------------------
// Input channel carries one item per stereo frame: action 0 processes the
// frame and yields one output item, action 1 clears every delay line (no
// output; ignored while hold mode is on).
// Configuration writes arrive on their own channel, always ready, and are to
// be made by the user while the core is idle; the core does not enforce this.
// Index 0..5 selects room feedback, damping, wet, dry, stereo width and hold
// mode; other indexes are dropped. A frame runs 6 setup steps on the shared
// multiply-accumulate unit, read/damp/low-pass/feedback/write steps on each
// of the 16 comb lines, read/write steps on each of the 8 allpass stages and
// mix steps per side. No new frame is taken until the last one is done; the
// single MAC and the single port of each line memory serialise the work.
// After reset and after each clear item taken with hold off the core sweeps
// the comb and allpass memories in one pass and is not ready. The output
// register holds a result until taken; the next frame is taken meanwhile
// and waits at its final step while the receiver stalls.
// ----------------------------------------------------------------------------
module stereo_comb_allpass_reverb_core
    import scar_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_item         i_in_item,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_item        o_out_item,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [2:0]       i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data
);
    t_state r_state, n_state;

    logic [16:0] r_cfg_fb;
    logic [14:0] r_cfg_damp;
    logic [17:0] r_cfg_wet;
    logic [17:0] r_cfg_dry;
    logic [16:0] r_cfg_width;
    logic        r_cfg_hold;

    logic [CA_W-1:0] r_clr;
    logic [CK_W-1:0] r_ck;
    logic [AK_W-1:0] r_ak;
    logic            r_side;
    t_cpos_tab       r_cpos;
    t_apos_tab       r_apos;
    logic signed [31:0] r_clp [2*COMB_N];

    logic signed [SAMPLE_BITS-1:0] r_inl, r_inr, r_ol;
    logic signed [31:0]    r_x, r_lp, r_l, r_r;
    logic [17:0]           r_wl, r_wr;
    logic signed [SUM_W-1:0] r_sum_l, r_sum_r;
    logic signed [ACC_W-1:0] r_acc;
    t_out_item             r_out;
    logic                  r_out_valid;

    logic [16:0] fb_c, width_c;
    logic [14:0] damp_c;
    logic [17:0] wet_c, dry_c;
    logic [9:0]  gain_c;

    logic signed [32:0] mul_a;
    logic signed [18:0] mul_b;
    logic               acc_en, acc_clr;

    logic               c_we, a_we;
    t_caddr             c_addr;
    t_aaddr             a_addr;
    logic signed [31:0] c_wdata, a_wdata, c_rdata, a_rdata;

    logic signed [63:0] rnd_f, rnd_f1;
    logic signed [31:0] lp_new, ap_v, ap_new_v;
    logic signed [SAMPLE_BITS-1:0] smp_sat;
    logic               accept_in, last_comb, last_ap, out_free;

    assign fb_c    = r_cfg_hold ? 17'(ONE) : ((r_cfg_fb > 17'(ONE)) ? 17'(ONE) : r_cfg_fb);
    assign damp_c  = r_cfg_hold ? 15'd0
                   : ((r_cfg_damp > 15'(DAMP_MAX)) ? 15'(DAMP_MAX) : r_cfg_damp);
    assign gain_c  = r_cfg_hold ? 10'd0 : 10'(GAIN);
    assign wet_c   = (r_cfg_wet > 18'(WET_MAX)) ? 18'(WET_MAX) : r_cfg_wet;
    assign dry_c   = (r_cfg_dry > 18'(DRY_MAX)) ? 18'(DRY_MAX) : r_cfg_dry;
    assign width_c = (r_cfg_width > 17'(ONE)) ? 17'(ONE) : r_cfg_width;

    assign rnd_f    = f_rnd(r_acc, COEF_FRAC_BITS);
    assign rnd_f1   = f_rnd(r_acc, COEF_FRAC_BITS + 1);
    assign lp_new   = f_sat32(rnd_f);
    assign smp_sat  = f_sat_smp(rnd_f);
    assign ap_v     = (r_ak < AK_W'(AP_N)) ? r_l : r_r;
    assign ap_new_v = f_sat32(64'(a_rdata) - 64'(ap_v));

    assign accept_in = i_in_valid && o_in_ready;
    assign last_comb = (r_ck == CK_W'(2*COMB_N-1));
    assign last_ap   = (r_ak == AK_W'(2*AP_N-1));
    assign out_free  = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_item.action) begin
                        n_state = r_cfg_hold ? ST_IDLE : ST_CLEAR;
                    end else begin
                        n_state = ST_GAIN;
                    end
                end
            end
            ST_CLEAR: begin
                if (r_clr == CA_W'(COMB_DEPTH-1)) n_state = ST_IDLE;
            end
            ST_GAIN: n_state = ST_XSAT;
            ST_XSAT: n_state = ST_WL;
            ST_WL:   n_state = ST_WLS;
            ST_WLS:  n_state = ST_WR;
            ST_WR:   n_state = ST_WRS;
            ST_WRS:  n_state = ST_C_RD;
            ST_C_RD: n_state = ST_C_M1;
            ST_C_M1: n_state = ST_C_M2;
            ST_C_M2: n_state = ST_C_LP;
            ST_C_LP: n_state = ST_C_FB;
            ST_C_FB: n_state = ST_C_WR;
            ST_C_WR: n_state = last_comb ? ST_A_RD : ST_C_RD;
            ST_A_RD: n_state = ST_A_WR;
            ST_A_WR: n_state = last_ap ? ST_MIX1 : ST_A_RD;
            ST_MIX1: n_state = ST_MIX2;
            ST_MIX2: n_state = ST_MIX3;
            ST_MIX3: n_state = ST_MIXS;
            ST_MIXS: begin
                if (!r_side) begin
                    n_state = ST_MIX1;
                end else if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        mul_a   = '0;
        mul_b   = '0;
        acc_en  = 1'b0;
        acc_clr = 1'b0;
        c_we    = 1'b0;
        a_we    = 1'b0;
        c_addr  = COMB_OFF[r_ck] + CA_W'(r_cpos[r_ck]);
        a_addr  = AP_OFF[r_ak] + AA_W'(r_apos[r_ak]);
        c_wdata = f_sat32(64'(r_x) + rnd_f);
        a_wdata = f_sat32(64'(ap_v) + 64'(a_rdata >>> 1));
        unique case (r_state)
            ST_CLEAR: begin
                c_addr  = r_clr;
                a_addr  = AA_W'(r_clr);
                c_we    = 1'b1;
                a_we    = (r_clr < CA_W'(AP_DEPTH));
                c_wdata = '0;
                a_wdata = '0;
            end
            ST_GAIN: begin
                mul_a = 33'(r_inl) + 33'(r_inr);
                mul_b = 19'(gain_c);
                acc_en = 1'b1; acc_clr = 1'b1;
            end
            ST_WL: begin
                mul_a = 33'(width_c) + 33'(ONE);
                mul_b = 19'(wet_c);
                acc_en = 1'b1; acc_clr = 1'b1;
            end
            ST_WR: begin
                mul_a = 33'(ONE) - 33'(width_c);
                mul_b = 19'(wet_c);
                acc_en = 1'b1; acc_clr = 1'b1;
            end
            ST_C_M1: begin
                mul_a = 33'(c_rdata);
                mul_b = 19'(ONE) - 19'(damp_c);
                acc_en = 1'b1; acc_clr = 1'b1;
            end
            ST_C_M2: begin
                mul_a = 33'(r_clp[r_ck]);
                mul_b = 19'(damp_c);
                acc_en = 1'b1;
            end
            ST_C_FB: begin
                mul_a = 33'(r_lp);
                mul_b = 19'(fb_c);
                acc_en = 1'b1; acc_clr = 1'b1;
            end
            ST_C_WR: c_we = 1'b1;
            ST_A_WR: a_we = 1'b1;
            ST_MIX1: begin
                mul_a = r_side ? 33'(r_r) : 33'(r_l);
                mul_b = 19'(r_wl);
                acc_en = 1'b1; acc_clr = 1'b1;
            end
            ST_MIX2: begin
                mul_a = r_side ? 33'(r_l) : 33'(r_r);
                mul_b = 19'(r_wr);
                acc_en = 1'b1;
            end
            ST_MIX3: begin
                mul_a = r_side ? 33'(r_inr) : 33'(r_inl);
                mul_b = 19'(dry_c);
                acc_en = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_ck        <= '0;
            r_ak        <= '0;
            r_side      <= 1'b0;
            r_cpos      <= '0;
            r_apos      <= '0;
            r_out_valid <= 1'b0;
            r_cfg_fb    <= 17'd55050;
            r_cfg_damp  <= 15'd13107;
            r_cfg_wet   <= 18'd196608;
            r_cfg_dry   <= 18'd0;
            r_cfg_width <= 17'd65536;
            r_cfg_hold  <= 1'b0;
            for (int i = 0; i < 2*COMB_N; i++) r_clp[i] <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_ROOM:  r_cfg_fb    <= i_cfg_data[16:0];
                    CFG_DAMP:  r_cfg_damp  <= i_cfg_data[14:0];
                    CFG_WET:   r_cfg_wet   <= i_cfg_data[17:0];
                    CFG_DRY:   r_cfg_dry   <= i_cfg_data[17:0];
                    CFG_WIDTH: r_cfg_width <= i_cfg_data[16:0];
                    CFG_HOLD:  r_cfg_hold  <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
            if (r_state == ST_MIXS && r_side && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (accept_in && i_in_item.action && !r_cfg_hold) begin
                r_clr  <= '0;
                r_cpos <= '0;
                r_apos <= '0;
                for (int i = 0; i < 2*COMB_N; i++) r_clp[i] <= '0;
            end
            if (r_state == ST_CLEAR) r_clr <= r_clr + 1'b1;
            if (r_state == ST_GAIN) begin
                r_ck   <= '0;
                r_ak   <= '0;
                r_side <= 1'b0;
            end
            if (r_state == ST_C_LP) r_clp[r_ck] <= lp_new;
            if (r_state == ST_C_WR) begin
                r_cpos[r_ck] <= (r_cpos[r_ck] == COMB_LAST[r_ck]) ? '0 : r_cpos[r_ck] + 1'b1;
                r_ck <= r_ck + 1'b1;
            end
            if (r_state == ST_A_WR) begin
                r_apos[r_ak] <= (r_apos[r_ak] == AP_LAST[r_ak]) ? '0 : r_apos[r_ak] + 1'b1;
                r_ak <= r_ak + 1'b1;
            end
            if (r_state == ST_MIXS && !r_side) r_side <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_inl <= i_in_item.in_left;
            r_inr <= i_in_item.in_right;
        end
        if (acc_en) begin
            r_acc <= (acc_clr ? '0 : r_acc) + ACC_W'(mul_a * mul_b);
        end
        unique case (r_state)
            ST_GAIN: begin
                r_sum_l <= '0;
                r_sum_r <= '0;
            end
            ST_XSAT: r_x  <= lp_new;
            ST_WLS:  r_wl <= 18'(rnd_f1);
            ST_WRS:  r_wr <= 18'(rnd_f1);
            ST_C_M1: begin
                if (r_ck < CK_W'(COMB_N)) r_sum_l <= r_sum_l + SUM_W'(c_rdata);
                else r_sum_r <= r_sum_r + SUM_W'(c_rdata);
            end
            ST_C_LP: r_lp <= lp_new;
            ST_C_WR: begin
                if (last_comb) begin
                    r_l <= f_sat32(64'(r_sum_l));
                    r_r <= f_sat32(64'(r_sum_r));
                end
            end
            ST_A_WR: begin
                if (r_ak < AK_W'(AP_N)) r_l <= ap_new_v;
                else r_r <= ap_new_v;
            end
            ST_MIXS: begin
                if (!r_side) begin
                    r_ol <= smp_sat;
                end else if (out_free) begin
                    r_out.out_left  <= r_ol;
                    r_out.out_right <= smp_sat;
                end
            end
            default: begin
            end
        endcase
    end

    scar_ram #(.WIDTH(32), .DEPTH(COMB_DEPTH)) u_comb_ram (
        .i_clk   (i_clk),
        .i_we    (c_we),
        .i_addr  (c_addr),
        .i_wdata (c_wdata),
        .o_rdata (c_rdata)
    );

    scar_ram #(.WIDTH(32), .DEPTH(AP_DEPTH)) u_ap_ram (
        .i_clk   (i_clk),
        .i_we    (a_we),
        .i_addr  (a_addr),
        .i_wdata (a_wdata),
        .o_rdata (a_rdata)
    );

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    assign o_cfg_ready = 1'b1;

    a_busy_after_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept_in && !i_in_item.action) |=> !o_in_ready)
        else $error("core ready right after taking a frame");

    a_out_from_mix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == ST_MIXS))
        else $error("output item raised outside the mix step");

    a_comb_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cpos[r_ck] <= COMB_LAST[r_ck])
        else $error("comb position past line end");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MIXS && r_side && !out_free) |=> (r_state == ST_MIXS))
        else $error("frame finished over an untaken item");
endmodule

// ===== tb/tb_reverb_checker.sv =====
// ----------------------------------------------------------------------------
// tb_reverb_checker
// Watches the frame, result and register channels of the reverb core, keeps
// its own comb/allpass state, predicts each output frame and compares it.
// ----------------------------------------------------------------------------
module tb_reverb_checker
    import scar_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_ready,
    input  t_in_item         i_in_item,
    input  logic             i_out_valid,
    input  logic             i_out_ready,
    input  t_out_item        i_out_item,
    input  logic             i_cfg_valid,
    input  logic             i_cfg_ready,
    input  logic [2:0]       i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data,
    output int               o_fail_count,
    output int               o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint UNIT     = 64'd65536;
    localparam int     RATE     = 44100;
    localparam int     SPREAD   = 23;
    localparam int     COMB_MEM = 22232;
    localparam int     AP_MEM   = 3218;

    int comb_base [8] = '{1116, 1188, 1277, 1356, 1422, 1491, 1557, 1617};
    int ap_base   [4] = '{556, 441, 341, 225};

    int comb_mem [COMB_MEM];
    int ap_mem   [AP_MEM];
    int comb_lp  [16];
    int comb_pos [16];
    int comb_base_addr [16];
    int comb_len [16];
    int ap_pos   [8];
    int ap_base_addr [8];
    int ap_len   [8];

    longint room_fb, damp, wet, dry, width;
    logic   hold;

    t_out_item frames_due [$];
    int        fail_count;

    assign o_fail_count = fail_count;
    assign o_pending    = frames_due.size();

    function automatic longint sat32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint round_shift(input longint v, input int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clamp(input longint v, input longint hi);
        return (v > hi) ? hi : v;
    endfunction

    function automatic int scaled_len(input int n);
        int l;
        l = (n * RATE + 22050) / 44100;
        return (l == 0) ? 1 : l;
    endfunction

    function automatic logic signed [23:0] sat_sample(input longint v);
        if (v > 64'sd8388607) return 24'sh7FFFFF;
        if (v < -64'sd8388608) return 24'sh800000;
        return v[23:0];
    endfunction

    task automatic wipe_lines();
        foreach (comb_mem[i]) comb_mem[i] = 0;
        foreach (ap_mem[i]) ap_mem[i] = 0;
        foreach (comb_lp[i]) comb_lp[i] = 0;
        foreach (comb_pos[i]) comb_pos[i] = 0;
        foreach (ap_pos[i]) ap_pos[i] = 0;
    endtask

    task automatic init_state();
        int off;
        off = 0;
        for (int ch = 0; ch < 2; ch++)
            for (int i = 0; i < 8; i++) begin
                comb_base_addr[ch*8+i] = off;
                comb_len[ch*8+i] = scaled_len(comb_base[i] + ch * SPREAD);
                off += comb_len[ch*8+i];
            end
        off = 0;
        for (int ch = 0; ch < 2; ch++)
            for (int i = 0; i < 4; i++) begin
                ap_base_addr[ch*4+i] = off;
                ap_len[ch*4+i] = scaled_len(ap_base[i] + ch * SPREAD);
                off += ap_len[ch*4+i];
            end
        wipe_lines();
        room_fb = 55050;
        damp    = 13107;
        wet     = 196608;
        dry     = 0;
        width   = 65536;
        hold    = 1'b0;
    endtask

    function automatic longint comb_tap(input int k, input longint x, input longint fb,
                                        input longint d);
        int     a;
        longint o, lp;
        a  = comb_base_addr[k] + comb_pos[k];
        o  = comb_mem[a];
        lp = sat32(round_shift((UNIT - d) * o + d * longint'(comb_lp[k]), 16));
        comb_lp[k] = int'(lp);
        comb_mem[a] = int'(sat32(x + round_shift(fb * lp, 16)));
        comb_pos[k] = (comb_pos[k] + 1 >= comb_len[k]) ? 0 : comb_pos[k] + 1;
        return o;
    endfunction

    function automatic longint allpass_tap(input int k, input longint v);
        int     a;
        longint b;
        a = ap_base_addr[k] + ap_pos[k];
        b = ap_mem[a];
        ap_mem[a] = int'(sat32(v + (b >>> 1)));
        ap_pos[k] = (ap_pos[k] + 1 >= ap_len[k]) ? 0 : ap_pos[k] + 1;
        return sat32(b - v);
    endfunction

    function automatic t_out_item reverb_frame(input longint l_in, input longint r_in);
        longint    fb, d, gain, wt, dr, wd, wl, wr, x, l, r;
        t_out_item res;
        fb   = clamp(room_fb, UNIT);
        d    = clamp(damp, 26214);
        gain = 983;
        if (hold) begin
            fb = UNIT;
            d = 0;
            gain = 0;
        end
        wt = clamp(wet, 3 * UNIT);
        dr = clamp(dry, 2 * UNIT);
        wd = clamp(width, UNIT);
        wl = round_shift((wd + UNIT) * wt, 17);
        wr = round_shift((UNIT - wd) * wt, 17);
        x = sat32(round_shift((l_in + r_in) * gain, 16));
        l = 0;
        r = 0;
        for (int i = 0; i < 8; i++) begin
            l += comb_tap(i, x, fb, d);
            r += comb_tap(8 + i, x, fb, d);
        end
        l = sat32(l);
        r = sat32(r);
        for (int i = 0; i < 4; i++) begin
            l = allpass_tap(i, l);
            r = allpass_tap(4 + i, r);
        end
        res.out_left  = sat_sample(round_shift(wl * l + wr * r + dr * l_in, 16));
        res.out_right = sat_sample(round_shift(wl * r + wr * l + dr * r_in, 16));
        return res;
    endfunction

    initial begin
        fail_count = 0;
        init_state();
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            init_state();
            frames_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_ROOM:  room_fb = i_cfg_data[16:0];
                    CFG_DAMP:  damp    = i_cfg_data[14:0];
                    CFG_WET:   wet     = i_cfg_data[17:0];
                    CFG_DRY:   dry     = i_cfg_data[17:0];
                    CFG_WIDTH: width   = i_cfg_data[16:0];
                    CFG_HOLD:  hold    = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (frames_due.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: unexpected output item L=%0d R=%0d", $realtime,
                                 i_out_item.out_left, i_out_item.out_right);
                end else begin
                    want = frames_due.pop_front();
                    if (want.out_left !== i_out_item.out_left ||
                        want.out_right !== i_out_item.out_right) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("%0t: mismatch L exp %0d got %0d, R exp %0d got %0d",
                                     $realtime, want.out_left, i_out_item.out_left,
                                     want.out_right, i_out_item.out_right);
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (i_in_item.action) begin
                    if (!hold) wipe_lines();
                end else begin
                    frames_due.push_back(reverb_frame(longint'(i_in_item.in_left),
                                                      longint'(i_in_item.in_right)));
                end
            end
        end
    end

endmodule

// ===== tb/tb_stereo_comb_allpass_reverb_core.sv =====
// ----------------------------------------------------------------------------
// tb_stereo_comb_allpass_reverb_core
// Drives frames, clears and register writes into the reverb core under random
// back-pressure; a separate checker predicts and compares every output item.
// ----------------------------------------------------------------------------
module tb_stereo_comb_allpass_reverb_core
    import scar_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 3000000;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_in_valid;
    logic             o_in_ready;
    t_in_item         i_in_item;
    logic             o_out_valid;
    logic             i_out_ready;
    t_out_item        o_out_item;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [2:0]       i_cfg_index;
    logic [CFG_W-1:0] i_cfg_data;

    int fail_count;
    int pending;
    int cycles;
    int send_idle_pct;
    int recv_idle_pct;
    int stall_request;

    stereo_comb_allpass_reverb_core DUT (.*);

    tb_reverb_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_item    (i_in_item),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_item   (o_out_item),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("** stereo_comb_allpass_reverb_core: FAILED **");
                $finish;
            end
        end
    end

    initial begin
        int hold_left;
        hold_left = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_request > 0) begin
                hold_left = stall_request;
                stall_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready = 1'b0;
            end else begin
                i_out_ready = ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic send_item(input logic act, input logic signed [23:0] l,
                             input logic signed [23:0] r);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_item.action   = act;
        i_in_item.in_left  = l;
        i_in_item.in_right = r;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic settle();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        i_cfg_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (150) @(negedge i_clk);
        while (!o_in_ready) @(negedge i_clk);
    endtask

    function automatic logic signed [23:0] rand_sample();
        case ($urandom_range(9))
            0: return 24'sh7FFFFF;
            1: return 24'sh800000;
            2: return 24'sh000000;
            default: return 24'($urandom);
        endcase
    endfunction

    initial begin
        logic [2:0] idx;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_item = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_ROOM;
        i_cfg_data = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        stall_request = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_item(1'b0, 24'sh7FFFFF, 24'sh7FFFFF);
        send_item(1'b0, 24'sh800000, 24'sh800000);
        send_item(1'b0, 24'sh7FFFFF, 24'sh800000);
        send_item(1'b0, 24'sh000000, 24'sh000000);
        send_item(1'b0, 24'sh800000, 24'sh7FFFFF);
        for (int i = 0; i < 6; i++) send_item(1'b0, rand_sample(), rand_sample());
        send_item(1'b1, 24'sh123456, 24'shABCDEF);
        send_item(1'b0, 24'sh7FFFFF, 24'sh7FFFFF);
        send_item(1'b0, 24'sh400000, 24'shC00000);
        settle();
        write_reg(CFG_DRY, 18'd131072);
        write_reg(CFG_HOLD, 18'd1);
        settle();
        for (int i = 0; i < 4; i++) send_item(1'b0, 24'sh7FFFFF, 24'sh800000);
        send_item(1'b1, 24'sh000000, 24'sh000000);
        send_item(1'b0, 24'sh000000, 24'sh000000);
        send_item(1'b0, 24'sh7FFFFF, 24'sh7FFFFF);

        for (int ph = 0; ph < 6; ph++) begin
            settle();
            case (ph)
                0: begin
                    write_reg(CFG_ROOM, 18'd65536);
                    write_reg(CFG_DAMP, 18'd26214);
                    write_reg(CFG_WET, 18'd196608);
                    write_reg(CFG_DRY, 18'd131072);
                    write_reg(CFG_WIDTH, 18'd65536);
                    write_reg(CFG_HOLD, 18'd0);
                end
                1: begin
                    write_reg(CFG_ROOM, 18'd0);
                    write_reg(CFG_DAMP, 18'd0);
                    write_reg(CFG_WET, 18'd0);
                    write_reg(CFG_WIDTH, 18'd0);
                    write_reg(3'd6, CFG_W'($urandom));
                    write_reg(3'd7, CFG_W'($urandom));
                end
                2: begin
                    write_reg(CFG_ROOM, 18'h3FFFF);
                    write_reg(CFG_DAMP, 18'h3FFFF);
                    write_reg(CFG_WET, 18'h3FFFF);
                    write_reg(CFG_DRY, 18'h3FFFF);
                    write_reg(CFG_WIDTH, 18'h3FFFF);
                end
                3: begin
                    for (int k = 0; k < 5; k++) begin
                        idx = 3'(k);
                        write_reg(idx, CFG_W'($urandom));
                    end
                    write_reg(CFG_HOLD, 18'h3FFFE);
                end
                4: begin
                    write_reg(CFG_WET, CFG_W'($urandom_range(196608)));
                    write_reg(CFG_WIDTH, CFG_W'($urandom_range(65536)));
                    write_reg(CFG_HOLD, 18'h3FFFF);
                end
                default: begin
                    write_reg(CFG_ROOM, CFG_W'($urandom_range(65536)));
                    write_reg(CFG_DAMP, CFG_W'($urandom_range(26214)));
                    write_reg(CFG_WET, CFG_W'($urandom_range(196608)));
                    write_reg(CFG_DRY, CFG_W'($urandom_range(131072)));
                    write_reg(CFG_WIDTH, CFG_W'($urandom_range(65536)));
                    write_reg(CFG_HOLD, 18'd0);
                end
            endcase
            send_idle_pct = (ph < 2) ? 36 : (ph < 4) ? 72 : 0;
            recv_idle_pct = (ph < 2) ? 72 : (ph < 4) ? 36 : 0;
            for (int i = 0; i < 265; i++) begin
                if (ph == 1 && i == 100) stall_request = 700;
                if (ph == 3 && i == 100) begin
                    @(negedge i_clk);
                    i_in_valid = 1'b0;
                    while (pending != 0) @(negedge i_clk);
                end
                send_item($urandom_range(199) == 0, rand_sample(), rand_sample());
            end
        end

        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (300) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("** stereo_comb_allpass_reverb_core: PASSED **");
        end else begin
            $display("** stereo_comb_allpass_reverb_core: FAILED **");
        end
        $finish;
    end

endmodule
